>>> src/eased_ramp_generator_top_defines.svh
// Assertion macros for the eased ramp generator.
// Needs no package; the macros assume a clock named clk and a reset named rst.
`ifndef EASED_RAMP_GENERATOR_TOP_DEFINES_SVH
`define EASED_RAMP_GENERATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ERG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ERG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/erg_pkg.sv
// Shared types and constants for the eased ramp generator.
// No dependencies; imported by eased_ramp_generator_top.
package erg_pkg;

  localparam int LEVEL_BITS    = 16;
  localparam int TICK_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DURATION  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_VALUE = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_DIR = 2'd3;

  localparam logic [1:0] MODE_DECEL  = 2'd0;
  localparam logic [1:0] MODE_INOUT  = 2'd1;
  localparam logic [1:0] MODE_SINE   = 2'd2;
  localparam logic [1:0] MODE_SMOOTH = 2'd3;

  localparam logic [TICK_BITS-1:0]  DURATION_RESET  = 16'd1000;
  localparam logic [1:0]            CURVE_RESET     = MODE_DECEL;
  localparam logic [LEVEL_BITS-1:0] END_VALUE_RESET = 16'hFFFF;
  localparam logic                  START_DIR_RESET = 1'b0;

  localparam logic                  CMD_TICK = 1'b0;

  // Half pi in Q2.30 and the divisors of the odd sine series terms.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  typedef struct packed {
    logic cmd;
    logic direction_request;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  finished;
    logic                  direction_now;
  } out_item_t;

endpackage

>>> src/eased_ramp_generator_top.sv
// Eased ramp generator: tick counter, divider, sine table and shared multiplier.
// Depends on erg_pkg and eased_ramp_generator_top_defines.svh.
//
// Each item (a tick or a direction request) yields one result item carrying the
// eased level, the finished flag and the current direction. The block handles one
// item at a time. The ratio elapsed/duration comes from a restoring divider that
// produces one quotient bit per cycle, FRACTION_BITS+1 bits in all, and the curve
// and the final scaling share one registered multiplier. The decelerate and in-out
// curves use the multiplier once before scaling, smoothstep twice, and out-sine once
// after two sine table reads unless the ratio reaches one; an item that leaves the
// ramp finished goes straight to the output and is offered in the next cycle. The
// next item is taken in the cycle after the result is taken.
`include "eased_ramp_generator_top_defines.svh"

module eased_ramp_generator_top
  import erg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int FRACTION_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  in_item_t                  item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output out_item_t                 result
);

  localparam int XW = FRACTION_BITS + 1;
  localparam int MW = (XW > LEVEL_BITS) ? XW : LEVEL_BITS;
  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = XW + AW + 1;
  localparam int CW = $clog2(XW + 1);
  localparam logic [XW-1:0] ONE_FX  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [XW-1:0] HALF_FX = ONE_FX >> 1;

  typedef logic [XW-1:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] one64;
    one64 = 64'd1 << FRACTION_BITS;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      a    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      a2   = (a * a) >> 30;
      term = a;
      sum  = a;
      for (int k = 0; k < 7; k++) begin
        term = (term * a2) >> 30;
        term = term / SERIES_DIV[k];
        if ((k & 1) == 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
      if (r > one64) begin
        r = one64;
      end
      rom[i] = r[XW-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_DIV      = 10'b0000000010,
    ST_PREP     = 10'b0000000100,
    ST_ROM_LO   = 10'b0000001000,
    ST_ROM_HI   = 10'b0000010000,
    ST_ROM_DIFF = 10'b0000100000,
    ST_MUL      = 10'b0001000000,
    ST_CURVE    = 10'b0010000000,
    ST_SCALE    = 10'b0100000000,
    ST_OUT      = 10'b1000000000
  } state_t;

  state_t                state;
  logic [TICK_BITS-1:0]  duration_ticks;
  logic [1:0]            curve_mode;
  logic [LEVEL_BITS-1:0] end_value;
  logic [TICK_BITS-1:0]  elapsed_ticks;
  logic                  running_direction;

  logic [TICK_BITS-1:0]  rem;
  logic [XW-1:0]         quot;
  logic [CW-1:0]         div_count;
  logic [AW-1:0]         rom_addr;
  logic [XW-1:0]         rom_q;
  logic [XW-1:0]         lo_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic                  idx_last;
  logic [XW-1:0]         x2_q;
  logic [XW-1:0]         curve_q;
  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [2*MW-1:0]       prod;
  logic                  second_pass;
  logic                  scale_pass;

  logic [TICK_BITS-1:0]  elapsed_next;
  logic                  direction_next;
  logic                  done_next;
  logic [TICK_BITS-1:0]  numer;
  logic [TICK_BITS:0]    shifted;
  logic                  div_ge;
  logic [TICK_BITS-1:0]  rem_next;
  logic [PW-1:0]         pos;
  logic [AW:0]           idx;
  logic [XW-1:0]         hi_val;
  logic [XW-1:0]         prod_f;
  logic [XW-1:0]         prod_fm1;
  logic [XW-1:0]         prod_fp1;
  logic [XW+1:0]         smooth_y;
  logic [XW-1:0]         smooth_clamped;
  logic [XW-1:0]         scale_op;

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = (state == ST_OUT);

  always_comb begin
    elapsed_next   = elapsed_ticks;
    direction_next = running_direction;
    if (item.cmd == CMD_TICK) begin
      elapsed_next = (elapsed_ticks >= duration_ticks) ? duration_ticks
                                                       : elapsed_ticks + 16'd1;
    end else if (item.direction_request != running_direction) begin
      direction_next = item.direction_request;
      elapsed_next   = duration_ticks - ((elapsed_ticks < duration_ticks) ? elapsed_ticks
                                                                          : duration_ticks);
    end
    done_next = (elapsed_next >= duration_ticks);
    numer     = (direction_next && (curve_mode == MODE_SINE)) ? duration_ticks - elapsed_next
                                                              : elapsed_next;

    shifted  = (div_count == CW'(XW)) ? {1'b0, rem} : {rem, 1'b0};
    div_ge   = (shifted >= {1'b0, duration_ticks});
    rem_next = div_ge ? TICK_BITS'(shifted - {1'b0, duration_ticks})
                      : TICK_BITS'(shifted);

    pos = PW'(quot) * PW'(SINE_TABLE_DEPTH);
    idx = pos[FRACTION_BITS +: AW+1];

    hi_val = idx_last ? ONE_FX : rom_q;
    if (hi_val < lo_q) begin
      hi_val = lo_q;
    end

    prod_f   = prod[FRACTION_BITS +: XW];
    prod_fm1 = prod[FRACTION_BITS-1 +: XW];
    prod_fp1 = prod[FRACTION_BITS+1 +: XW];

    smooth_y = (XW+2)'(x2_q) + (XW+2)'({x2_q, 1'b0}) - (XW+2)'({prod_f, 1'b0});
    smooth_clamped = (smooth_y > (XW+2)'(ONE_FX)) ? ONE_FX : smooth_y[XW-1:0];

    if (!running_direction) begin
      scale_op = curve_q;
    end else if (curve_mode == MODE_SINE) begin
      scale_op = curve_q;
    end else begin
      scale_op = ONE_FX - curve_q;
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      duration_ticks    <= DURATION_RESET;
      curve_mode        <= CURVE_RESET;
      end_value         <= END_VALUE_RESET;
      elapsed_ticks     <= '0;
      running_direction <= START_DIR_RESET;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            elapsed_ticks          <= elapsed_next;
            running_direction      <= direction_next;
            result.finished        <= done_next;
            result.direction_now   <= direction_next;
            second_pass            <= 1'b0;
            scale_pass             <= 1'b0;
            if (done_next) begin
              result.level <= direction_next ? '0 : end_value;
              state        <= ST_OUT;
            end else begin
              rem       <= numer;
              div_count <= CW'(XW);
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem       <= rem_next;
          quot      <= {quot[XW-2:0], div_ge};
          div_count <= div_count - CW'(1);
          if (div_count == CW'(1)) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          case (curve_mode)
            MODE_DECEL: begin
              mul_a <= MW'(ONE_FX - quot);
              mul_b <= MW'(ONE_FX - quot);
              state <= ST_MUL;
            end
            MODE_INOUT: begin
              if (quot < HALF_FX) begin
                mul_a <= MW'(quot);
                mul_b <= MW'(quot);
              end else begin
                mul_a <= MW'({ONE_FX - quot, 1'b0});
                mul_b <= MW'({ONE_FX - quot, 1'b0});
              end
              state <= ST_MUL;
            end
            MODE_SINE: begin
              if (idx >= (AW+1)'(SINE_TABLE_DEPTH)) begin
                curve_q <= ONE_FX;
                state   <= ST_SCALE;
              end else begin
                rom_addr <= idx[AW-1:0];
                frac_q   <= pos[FRACTION_BITS-1:0];
                idx_last <= (idx == (AW+1)'(SINE_TABLE_DEPTH - 1));
                state    <= ST_ROM_LO;
              end
            end
            default: begin
              mul_a <= MW'(quot);
              mul_b <= MW'(quot);
              state <= ST_MUL;
            end
          endcase
        end
        ST_ROM_LO: begin
          if (!idx_last) begin
            rom_addr <= rom_addr + AW'(1);
          end
          state <= ST_ROM_HI;
        end
        ST_ROM_HI: begin
          lo_q  <= rom_q;
          state <= ST_ROM_DIFF;
        end
        ST_ROM_DIFF: begin
          mul_a <= MW'(hi_val - lo_q);
          mul_b <= MW'(frac_q);
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          state <= ST_CURVE;
        end
        ST_CURVE: begin
          if (scale_pass) begin
            result.level <= prod[FRACTION_BITS +: LEVEL_BITS];
            state        <= ST_OUT;
          end else begin
            state <= ST_SCALE;
            case (curve_mode)
              MODE_DECEL: begin
                curve_q <= ONE_FX - prod_f;
              end
              MODE_INOUT: begin
                curve_q <= (quot < HALF_FX) ? prod_fm1 : ONE_FX - prod_fp1;
              end
              MODE_SINE: begin
                curve_q <= lo_q + prod_f;
              end
              default: begin
                if (!second_pass) begin
                  x2_q        <= prod_f;
                  mul_a       <= MW'(prod_f);
                  mul_b       <= MW'(quot);
                  second_pass <= 1'b1;
                  state       <= ST_MUL;
                end else begin
                  curve_q <= smooth_clamped;
                end
              end
            endcase
          end
        end
        ST_SCALE: begin
          mul_a      <= MW'(scale_op);
          mul_b      <= MW'(end_value);
          scale_pass <= 1'b1;
          state      <= ST_MUL;
        end
        ST_OUT: begin
          if (!result_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          REG_DURATION:  duration_ticks <= cfg_data;
          REG_CURVE:     curve_mode     <= cfg_data[1:0];
          REG_END_VALUE: end_value      <= cfg_data;
          REG_START_DIR: begin
            running_direction <= cfg_data[0];
            elapsed_ticks     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ERG_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall,
                   "Block took a second item before the first result was out.")
  `ERG_ASSERT_NOW(a_finished_matches_state, result_valid,
                  result.finished == (elapsed_ticks >= duration_ticks),
                  "Finished flag disagrees with the elapsed tick counter.")
  `ERG_ASSERT_NOW(a_finished_forward_level,
                  result_valid && result.finished && !result.direction_now,
                  result.level == end_value,
                  "A finished forward ramp must sit at the end value.")
  `ERG_ASSERT_NOW(a_finished_backward_level,
                  result_valid && result.finished && result.direction_now,
                  result.level == '0,
                  "A finished backward ramp must sit at zero.")

endmodule

>>> test/eased_ramp_generator_top_tb.sv
// Self-checking testbench for the eased ramp generator, with its own ramp and curve predictor.
// Depends on erg_pkg and eased_ramp_generator_top; it drives ticks and direction requests
// under random idling and checks every result item against the predicted level and flags.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import erg_pkg::*;

  localparam int FRAC = 16;
  localparam int LUT_DEPTH = 256;
  localparam bit [63:0] ONE_FX = 64'd1 << FRAC;
  localparam logic CMD_DIRECTION = 1'b1;
  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_BACKWARD = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 13;
  localparam int ITEMS_PER_PHASE = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;

  eased_ramp_generator_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and its copy of the registers.
  bit [16:0] sine_lut [LUT_DEPTH];
  logic [TICK_BITS-1:0] ramp_duration = DURATION_RESET;
  logic [1:0] ramp_mode = CURVE_RESET;
  logic [LEVEL_BITS-1:0] ramp_end = END_VALUE_RESET;
  logic [TICK_BITS-1:0] ramp_elapsed = '0;
  logic ramp_dir = START_DIR_RESET;

  in_item_t ramp_cmds[$];
  out_item_t levels_due[$];
  out_item_t level_want;
  int cmds_queued = 0;
  int results_seen = 0;
  int failures = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit item_taken = 1'b0;

  function automatic bit [63:0] sine_series_q30(bit [63:0] a);
    bit [63:0] a2, term, sum;
    a2 = (a * a) >> 30;
    term = a;
    sum = a;
    for (int k = 1; k <= 7; k++) begin
      term = (term * a2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic void fill_sine_lut();
    bit [63:0] a, r;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      a = (HALF_PI_Q30 * 64'(i)) / 64'(LUT_DEPTH);
      r = (sine_series_q30(a) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (r > ONE_FX) r = ONE_FX;
      sine_lut[i] = r[16:0];
    end
  endfunction

  function automatic bit [63:0] sine_ease(bit [63:0] x);
    bit [63:0] pos, idx, frac, lo, hi;
    bit [7:0] slot;
    pos = x * 64'(LUT_DEPTH);
    idx = pos >> FRAC;
    frac = pos & (ONE_FX - 64'd1);
    if (idx >= 64'(LUT_DEPTH)) return ONE_FX;
    slot = idx[7:0];
    lo = 64'(sine_lut[slot]);
    hi = (idx + 64'd1 < 64'(LUT_DEPTH)) ? 64'(sine_lut[slot + 8'd1]) : ONE_FX;
    if (hi < lo) hi = lo;
    return lo + (((hi - lo) * frac) >> FRAC);
  endfunction

  function automatic bit [63:0] ease(bit [63:0] x);
    bit [63:0] u, v, x2, x3, y;
    if (x > ONE_FX) x = ONE_FX;
    case (ramp_mode)
      MODE_DECEL: begin
        u = ONE_FX - x;
        return ONE_FX - ((u * u) >> FRAC);
      end
      MODE_INOUT: begin
        if (x < (ONE_FX >> 1)) return (64'd2 * x * x) >> FRAC;
        v = 64'd2 * (ONE_FX - x);
        return ONE_FX - ((v * v) >> (FRAC + 1));
      end
      MODE_SINE: begin
        return sine_ease(x);
      end
      default: begin
        x2 = (x * x) >> FRAC;
        x3 = (x2 * x) >> FRAC;
        y = 64'd3 * x2 - 64'd2 * x3;
        return (y > ONE_FX) ? ONE_FX : y;
      end
    endcase
  endfunction

  function automatic bit [63:0] tick_ratio(bit [63:0] t, bit [63:0] d);
    if (d == 64'd0) return ONE_FX;
    if (t > d) t = d;
    return (t << FRAC) / d;
  endfunction

  function automatic out_item_t advance_ramp(in_item_t it);
    bit [63:0] d, t, lvl;
    bit done;
    out_item_t r;
    d = 64'(ramp_duration);
    t = 64'(ramp_elapsed);
    if (it.cmd == CMD_TICK) begin
      t = (t >= d) ? d : t + 64'd1;
    end else if (it.direction_request != ramp_dir) begin
      ramp_dir = it.direction_request;
      t = d - ((t < d) ? t : d);
    end
    ramp_elapsed = t[TICK_BITS-1:0];
    done = (t >= d);
    if (ramp_dir == DIR_FORWARD) begin
      lvl = done ? 64'(ramp_end) : (ease(tick_ratio(t, d)) * 64'(ramp_end)) >> FRAC;
    end else if (done) begin
      lvl = '0;
    end else if (ramp_mode == MODE_SINE) begin
      lvl = (ease(tick_ratio(d - t, d)) * 64'(ramp_end)) >> FRAC;
    end else begin
      lvl = ((ONE_FX - ease(tick_ratio(t, d))) * 64'(ramp_end)) >> FRAC;
    end
    r.level = lvl[LEVEL_BITS-1:0];
    r.finished = done;
    r.direction_now = ramp_dir;
    return r;
  endfunction

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DURATION: ramp_duration = data;
      REG_CURVE: ramp_mode = data[1:0];
      REG_END_VALUE: ramp_end = data;
      REG_START_DIR: begin
        ramp_dir = data[0];
        ramp_elapsed = '0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cmd(logic cmd, logic dir);
    in_item_t it;
    it.cmd = cmd;
    it.direction_request = dir;
    ramp_cmds.push_back(it);
    cmds_queued++;
  endtask

  task automatic wait_drained();
    wait (results_seen == cmds_queued);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (ramp_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= ramp_cmds.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    item_taken = 1'b0;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("eased_ramp_generator_top test failed");
      $finish;
    end
    if (!rst) begin
      if (item_valid && !item_stall) begin
        levels_due.push_back(advance_ramp(item));
        item_taken = 1'b1;
      end
      if (result_valid && !result_stall) begin
        if (levels_due.size() == 0) begin
          $error("Result item with no expectation waiting: level %0d", result.level);
          failures++;
        end else begin
          level_want = levels_due.pop_front();
          results_seen++;
          if (result.level !== level_want.level) begin
            $error("level: expected %0d, actual %0d", level_want.level, result.level);
            failures++;
          end
          if (result.finished !== level_want.finished) begin
            $error("finished: expected %0b, actual %0b", level_want.finished, result.finished);
            failures++;
          end
          if (result.direction_now !== level_want.direction_now) begin
            $error("direction_now: expected %0b, actual %0b", level_want.direction_now,
                   result.direction_now);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] data;
    int pick;
    fill_sine_lut();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_TICK, 1'b1);
    queue_cmd(CMD_DIRECTION, DIR_BACKWARD);
    queue_cmd(CMD_DIRECTION, DIR_BACKWARD);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_DIRECTION, DIR_FORWARD);
    wait_drained();

    write_register(REG_DURATION, 16'd1);
    write_register(REG_CURVE, {14'd0, MODE_SINE});
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_DIRECTION, DIR_BACKWARD);
    queue_cmd(CMD_TICK, 1'b1);
    wait_drained();

    // A zero duration counts as finished throughout.
    write_register(REG_DURATION, 16'd0);
    write_register(REG_END_VALUE, 16'd0);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_DIRECTION, DIR_FORWARD);
    wait_drained();

    write_register(REG_DURATION, 16'hFFFF);
    write_register(REG_CURVE, {14'h3FFF, MODE_SMOOTH});
    write_register(REG_END_VALUE, 16'hFFFF);
    write_register(REG_START_DIR, 16'hFFFF);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_DIRECTION, DIR_FORWARD);
    wait_drained();

    write_register(REG_DURATION, 16'd4);
    write_register(REG_CURVE, {14'd0, MODE_INOUT});
    write_register(REG_END_VALUE, 16'h8000);
    write_register(REG_START_DIR, 16'd0);
    repeat (5) queue_cmd(CMD_TICK, 1'b0);
    wait_drained();

    // Lowering the duration below the elapsed count, first before a tick, then before a flip.
    write_register(REG_DURATION, 16'd2);
    queue_cmd(CMD_TICK, 1'b0);
    wait_drained();
    write_register(REG_DURATION, 16'd1);
    queue_cmd(CMD_DIRECTION, DIR_BACKWARD);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      pick = $urandom_range(19);
      if (pick == 0) data = 16'd0;
      else if (pick == 1) data = 16'hFFFF;
      else if (pick == 2) data = CFG_DATA_BITS'($urandom_range(65535, 1));
      else if (pick <= 5) data = 16'd1;
      else data = CFG_DATA_BITS'($urandom_range(60, 2));
      write_register(REG_DURATION, data);
      data = CFG_DATA_BITS'($urandom);
      data[1:0] = 2'(p % 4);
      write_register(REG_CURVE, data);
      pick = $urandom_range(9);
      if (pick == 0) data = 16'd0;
      else if (pick == 1) data = 16'hFFFF;
      else data = CFG_DATA_BITS'($urandom);
      write_register(REG_END_VALUE, data);
      if (p == 0 || $urandom_range(1) == 1) begin
        write_register(REG_START_DIR, CFG_DATA_BITS'($urandom));
      end
      if (p == 4 || p == 8) hold_left = 300;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_cmd(($urandom_range(99) < 65) ? CMD_TICK : CMD_DIRECTION,
                  1'($urandom_range(1)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (levels_due.size() != 0) begin
      $error("%0d expected result items never arrived", levels_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("eased_ramp_generator_top test passed");
    end else begin
      $display("eased_ramp_generator_top test failed");
    end
    $finish;
  end

endmodule
